// File: rtl/hmmned_pkg.sv
// shared types, constants and helpers for the hmm next-emission distribution unit
package hmmned_pkg;

  localparam int MAX_STATES  = 8;
  localparam int MAX_SYMBOLS = 8;
  localparam int PROB_BITS   = 16;
  localparam int FRAC_BITS   = PROB_BITS - 1;
  localparam int PROD_W      = PROB_BITS + 1;
  localparam int STATE_W     = $clog2(MAX_STATES);
  localparam int SYM_W       = $clog2(MAX_SYMBOLS);
  localparam int IDX_W       = 3;
  localparam int COUNT_W     = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int FIFO_DEPTH  = MAX_SYMBOLS;
  localparam int FIFO_PTR_W  = SYM_W;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_LOAD_PI = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SYMBOLS = 1'b1;

  // token handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic                 sym_phase;
    logic                 first;
    logic [IDX_W-1:0]     idx;
    logic [PROB_BITS-1:0] data;
  } tok_t;

  // matrix write broadcast to all cells
  typedef struct packed {
    logic                 a_en;
    logic                 b_en;
    logic [IDX_W-1:0]     row;
    logic [IDX_W-1:0]     col;
    logic [PROB_BITS-1:0] value;
  } wr_t;

  typedef struct packed {
    logic [IDX_W-1:0]     symbol;
    logic [PROB_BITS-1:0] prob;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic logic [PROB_BITS-1:0] sat_add(input logic [PROB_BITS-1:0] a,
                                                   input logic [PROD_W-1:0] b);
    logic [PROD_W:0] sum;
    sum = {2'b00, a} + {1'b0, b};
    if (sum > {2'b00, {PROB_BITS{1'b1}}}) begin
      return {PROB_BITS{1'b1}};
    end
    return sum[PROB_BITS-1:0];
  endfunction

endpackage

// File: rtl/hmmned_cell.sv
// one chain cell: holds column t of A, row t of B and next-state value t, with one mac
module hmmned_cell import hmmned_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [STATE_W-1:0] cell_idx_i,
  input  logic [COUNT_W-1:0] num_states_i,
  input  wr_t                wr_i,
  input  tok_t               tok_i,
  output tok_t               tok_o
);

  logic [PROB_BITS-1:0] a_col_q [MAX_STATES];
  logic [PROB_BITS-1:0] b_row_q [MAX_SYMBOLS];
  logic [PROB_BITS-1:0] acc_q, acc_d;

  tok_t                 s1_tok_q;
  logic [PROD_W-1:0]    s1_prod_q, s1_prod_d;
  tok_t                 s2_tok_q, s2_tok_d;

  logic [PROB_BITS-1:0]   mul_a, mul_b;
  logic [2*PROB_BITS-1:0] mul_full;
  logic                   in_use;

  always_ff @(posedge clk_i) begin
    if (wr_i.a_en && wr_i.col[STATE_W-1:0] == cell_idx_i) begin
      a_col_q[wr_i.row[STATE_W-1:0]] <= wr_i.value;
    end
    if (wr_i.b_en && wr_i.row[STATE_W-1:0] == cell_idx_i) begin
      b_row_q[wr_i.col[SYM_W-1:0]] <= wr_i.value;
    end
  end

  // cells beyond the active state count add nothing to a symbol sum
  assign in_use = {{(COUNT_W-STATE_W){1'b0}}, cell_idx_i} < num_states_i;

  always_comb begin
    if (tok_i.sym_phase) begin
      mul_a = acc_q;
      mul_b = b_row_q[tok_i.idx[SYM_W-1:0]];
    end else begin
      mul_a = tok_i.data;
      mul_b = a_col_q[tok_i.idx[STATE_W-1:0]];
    end
    mul_full = mul_a * mul_b;
    s1_prod_d = mul_full[FRAC_BITS +: PROD_W];
    if (tok_i.sym_phase && !in_use) begin
      s1_prod_d = '0;
    end
  end

  always_comb begin
    s2_tok_d = s1_tok_q;
    acc_d    = acc_q;
    if (s1_tok_q.valid) begin
      if (s1_tok_q.sym_phase) begin
        s2_tok_d.data = sat_add(s1_tok_q.data, s1_prod_q);
      end else if (s1_tok_q.first) begin
        acc_d = sat_add('0, s1_prod_q);
      end else begin
        acc_d = sat_add(acc_q, s1_prod_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tok_q <= '0;
      s2_tok_q <= '0;
    end else begin
      s1_tok_q <= tok_i;
      s2_tok_q <= s2_tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_prod_q <= s1_prod_d;
    acc_q     <= acc_d;
  end

  assign tok_o = s2_tok_q;

endmodule

// File: rtl/hmmned_out_fifo.sv
// result queue between the cell chain and the output channel
module hmmned_out_fifo import hmmned_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  res_t       push_data_i,
  input  logic       pop_i,
  output res_t       head_o,
  output fifo_stat_t stat_o
);

  res_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_W:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));

endmodule

// File: rtl/hmm_next_emission_distribution_unit.sv
// load requests are taken back to back while idle. compute request: waits for the result
// queue to drain, feeds n initial values, a gap state, then m symbol tokens into a chain of
// 8 cells (registers s1 and s2 in each cell); results enter the result queue one per cycle
// and the next request is taken once the last result has entered the queue.
// reset: counts return to 8, control and queue clear; stored matrices are kept.
module hmm_next_emission_distribution_unit import hmmned_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [2:0]           row_i,
  input  logic [2:0]           col_i,
  input  logic [15:0]          value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           symbol_o,
  output logic [15:0]          probability_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COUNT_W-1:0]   cfg_data_i
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_WAIT  = 6'b000010,
    ST_FEED1 = 6'b000100,
    ST_GAP   = 6'b001000,
    ST_FEED2 = 6'b010000,
    ST_DRAIN = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic [COUNT_W-1:0]   num_states_q, num_symbols_q;
  logic [COUNT_W-1:0]   n_eff, m_eff;
  logic [PROB_BITS-1:0] pi_q [MAX_STATES];

  logic       in_accept;
  cmd_e       cmd;
  wr_t        wr;
  tok_t       inj_tok;
  tok_t       chain [MAX_STATES+1];
  logic       fifo_push;
  res_t       fifo_in;
  res_t       fifo_head;
  fifo_stat_t fifo_stat;
  logic       pop;

  assign cmd        = cmd_e'(command_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q  <= COUNT_W'(MAX_STATES);
      num_symbols_q <= COUNT_W'(MAX_SYMBOLS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NUM_STATES:  num_states_q  <= cfg_data_i;
        CFG_NUM_SYMBOLS: num_symbols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, above the maximum acts as the maximum
  always_comb begin
    priority if (num_states_q == '0) n_eff = COUNT_W'(1);
    else if (num_states_q > COUNT_W'(MAX_STATES)) n_eff = COUNT_W'(MAX_STATES);
    else n_eff = num_states_q;
    priority if (num_symbols_q == '0) m_eff = COUNT_W'(1);
    else if (num_symbols_q > COUNT_W'(MAX_SYMBOLS)) m_eff = COUNT_W'(MAX_SYMBOLS);
    else m_eff = num_symbols_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && cmd == CMD_LOAD_PI) begin
      pi_q[row_i[STATE_W-1:0]] <= value_i;
    end
  end

  assign wr.a_en  = in_accept && (cmd == CMD_LOAD_A);
  assign wr.b_en  = in_accept && (cmd == CMD_LOAD_B);
  assign wr.row   = row_i;
  assign wr.col   = col_i;
  assign wr.value = value_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    inj_tok = '0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_accept && cmd == CMD_COMPUTE) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (fifo_stat.empty) state_d = ST_FEED1;
      end
      ST_FEED1: begin
        inj_tok.valid = 1'b1;
        inj_tok.first = (cnt_q == '0);
        inj_tok.idx   = cnt_q;
        inj_tok.data  = pi_q[cnt_q[STATE_W-1:0]];
        cnt_d = cnt_q + 1'b1;
        if ({1'b0, cnt_q} == n_eff - 1'b1) begin
          cnt_d   = '0;
          state_d = ST_GAP;
        end
      end
      // lets the last state value settle before symbol tokens read it
      ST_GAP: state_d = ST_FEED2;
      ST_FEED2: begin
        inj_tok.valid     = 1'b1;
        inj_tok.sym_phase = 1'b1;
        inj_tok.idx       = cnt_q;
        cnt_d = cnt_q + 1'b1;
        if ({1'b0, cnt_q} == m_eff - 1'b1) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (fifo_push && fifo_in.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign chain[0] = inj_tok;

  for (genvar i = 0; i < MAX_STATES; i++) begin : g_cell
    hmmned_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cell_idx_i   (STATE_W'(i)),
      .num_states_i (n_eff),
      .wr_i         (wr),
      .tok_i        (chain[i]),
      .tok_o        (chain[i+1])
    );
  end

  assign fifo_push      = chain[MAX_STATES].valid && chain[MAX_STATES].sym_phase;
  assign fifo_in.symbol = chain[MAX_STATES].idx;
  assign fifo_in.prob   = chain[MAX_STATES].data;
  assign fifo_in.last   = ({1'b0, chain[MAX_STATES].idx} == m_eff - 1'b1);

  assign pop = out_valid_o && !out_stall_i;

  hmmned_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (fifo_in),
    .pop_i       (pop),
    .head_o      (fifo_head),
    .stat_o      (fifo_stat)
  );

  assign out_valid_o   = !fifo_stat.empty;
  assign symbol_o      = fifo_head.symbol;
  assign probability_o = fifo_head.prob;
  assign last_o        = fifo_head.last;

  a_push_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> (state_q == ST_FEED2 || state_q == ST_DRAIN))
    else $error("result left the chain outside a compute");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_stat.full)
    else $error("result queue overflow");

  a_empty_in_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FEED1 |-> fifo_stat.empty)
    else $error("compute started with results still queued");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && fifo_push && fifo_in.last) |=> state_q == ST_IDLE)
    else $error("last result did not end the compute");

endmodule

// File: tb/tb_hmm_next_emission_distribution_unit.sv
// self-checking testbench for the hmm next-emission distribution unit
`timescale 1ns / 100ps

module tb_hmm_next_emission_distribution_unit import hmmned_pkg::*;;

  localparam int SYM_CAP   = (MAX_SYMBOLS < 8) ? MAX_SYMBOLS : 8;
  localparam int SETTLE    = 64;
  localparam logic [15:0] PMAX = 16'hFFFF;

  typedef struct {
    cmd_e        cmd;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] value;
    bit          drain;
  } req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           command_i = '0;
  logic [2:0]           row_i = '0;
  logic [2:0]           col_i = '0;
  logic [15:0]          value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [2:0]           symbol_o;
  logic [15:0]          probability_o;
  logic                 last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COUNT_W-1:0]   cfg_data_i = '0;

  hmm_next_emission_distribution_unit uut (.*);

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // request stream and expected symbol probabilities
  req_t req_q[$];
  res_t prob_exp_q[$];
  int   err_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  // predictor copy of the block
  logic [15:0]        trans_mem [MAX_STATES][MAX_STATES];
  logic [15:0]        emis_mem  [MAX_STATES][MAX_SYMBOLS];
  logic [15:0]        init_mem  [MAX_STATES];
  logic [15:0]        next_dist [MAX_STATES];
  logic [COUNT_W-1:0] cur_states = 4'd8;
  logic [COUNT_W-1:0] cur_symbols = 4'd8;

  // generator view: which entries have been loaded so far
  bit a_seen [MAX_STATES][MAX_STATES];
  bit b_seen [MAX_STATES][MAX_SYMBOLS];
  bit pi_seen [MAX_STATES];
  int gen_n = 8;
  int gen_m = 8;

  function automatic int eff_count(input logic [COUNT_W-1:0] v, input int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [15:0] mac_sat(input logic [15:0] acc, input logic [15:0] a,
                                          input logic [15:0] b);
    longint sum;
    sum = longint'(acc) + ((longint'(a) * longint'(b)) >> FRAC_BITS);
    return (sum > longint'(PMAX)) ? PMAX : sum[15:0];
  endfunction

  function automatic void predict_request(input req_t r);
    int   n, m;
    logic [15:0] acc;
    res_t res;
    case (r.cmd)
      CMD_LOAD_A:  trans_mem[r.row][r.col] = r.value;
      CMD_LOAD_B:  emis_mem[r.row][r.col] = r.value;
      CMD_LOAD_PI: init_mem[r.row] = r.value;
      default: begin
        n = eff_count(cur_states, MAX_STATES);
        m = eff_count(cur_symbols, SYM_CAP);
        for (int t = 0; t < n; t++) begin
          acc = '0;
          for (int s = 0; s < n; s++) acc = mac_sat(acc, init_mem[s], trans_mem[s][t]);
          next_dist[t] = acc;
        end
        for (int k = 0; k < m; k++) begin
          acc = '0;
          for (int t = 0; t < n; t++) acc = mac_sat(acc, next_dist[t], emis_mem[t][k]);
          res.symbol = k[2:0];
          res.prob   = acc;
          res.last   = (k + 1 == m);
          prob_exp_q.insert(prob_exp_q.size(), res);
        end
      end
    endcase
  endfunction

  function automatic logic [15:0] rand_prob();
    case ($urandom_range(4))
      0: return 16'($urandom());
      1: return PMAX;
      2: return 16'h0000;
      3: return 16'h8000;
      default: return 16'($urandom_range(16'h2000));
    endcase
  endfunction

  function automatic void push_req(input cmd_e cmd, input logic [2:0] row, input logic [2:0] col,
                                   input logic [15:0] value, input bit drain);
    req_t r;
    r.cmd = cmd;
    r.row = row;
    r.col = col;
    r.value = value;
    r.drain = drain;
    case (cmd)
      CMD_LOAD_A:  a_seen[row][col] = 1'b1;
      CMD_LOAD_B:  b_seen[row][col] = 1'b1;
      CMD_LOAD_PI: pi_seen[row] = 1'b1;
      default: ;
    endcase
    req_q.insert(req_q.size(), r);
  endfunction

  // a compute never reads an entry that was never loaded
  function automatic void push_compute(input bit drain);
    for (int s = 0; s < gen_n; s++) begin
      if (!pi_seen[s]) push_req(CMD_LOAD_PI, s[2:0], 3'($urandom()), rand_prob(), 1'b0);
      for (int t = 0; t < gen_n; t++)
        if (!a_seen[s][t]) push_req(CMD_LOAD_A, s[2:0], t[2:0], rand_prob(), 1'b0);
      for (int k = 0; k < gen_m; k++)
        if (!b_seen[s][k]) push_req(CMD_LOAD_B, s[2:0], k[2:0], rand_prob(), 1'b0);
    end
    push_req(CMD_COMPUTE, 3'($urandom()), 3'($urandom()), 16'($urandom()), drain);
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_request(req_q.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(req_q[0].drain && prob_exp_q.size() != 0)) begin
          in_valid_i <= 1'b1;
          command_i  <= req_q[0].cmd;
          row_i      <= req_q[0].row;
          col_i      <= req_q[0].col;
          value_i    <= req_q[0].value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  res_t mon_want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (prob_exp_q.size() == 0) begin
          $error("unexpected result: symbol %0d probability %0h", symbol_o, probability_o);
          err_cnt++;
        end else begin
          mon_want = prob_exp_q.pop_front();
          if (symbol_o !== mon_want.symbol) begin
            $error("symbol: expected %0d, got %0d", mon_want.symbol, symbol_o);
            err_cnt++;
          end
          if (probability_o !== mon_want.prob) begin
            $error("probability: expected %0h, got %0h", mon_want.prob, probability_o);
            err_cnt++;
          end
          if (last_o !== mon_want.last) begin
            $error("last: expected %0b, got %0b", mon_want.last, last_o);
            err_cnt++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_NUM_STATES) cur_states = data;
    else cur_symbols = data;
  endtask

  task automatic set_counts(input logic [COUNT_W-1:0] n_cfg, input logic [COUNT_W-1:0] m_cfg);
    write_reg(CFG_NUM_STATES, n_cfg);
    write_reg(CFG_NUM_SYMBOLS, m_cfg);
    gen_n = eff_count(n_cfg, MAX_STATES);
    gen_m = eff_count(m_cfg, SYM_CAP);
  endtask

  // loads leave no result behind, so give the block time to settle too
  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_q.size() != 0 || in_valid_i || prob_exp_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] n_cfg, input logic [COUNT_W-1:0] m_cfg,
                           input int idle, input int stall, input int count,
                           input bit pressure);
    int roll;
    set_counts(n_cfg, m_cfg);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 30) push_compute(pressure && ($urandom_range(2) == 0));
      else push_req(cmd_e'($urandom_range(2)), 3'($urandom()), 3'($urandom()), rand_prob(),
                    1'b0);
    end
    push_compute(pressure);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: two states, three symbols
    set_counts(4'd2, 4'd3);
    push_req(CMD_LOAD_PI, 3'd0, 3'd7, 16'h8000, 1'b0);
    push_req(CMD_LOAD_PI, 3'd1, 3'd0, 16'h0000, 1'b0);
    push_req(CMD_LOAD_A, 3'd0, 3'd0, 16'h8000, 1'b0);
    push_req(CMD_LOAD_A, 3'd0, 3'd1, 16'hFFFF, 1'b0);
    push_req(CMD_LOAD_A, 3'd1, 3'd0, 16'h0000, 1'b0);
    push_req(CMD_LOAD_A, 3'd1, 3'd1, 16'h4000, 1'b0);
    push_req(CMD_LOAD_B, 3'd0, 3'd0, 16'h8000, 1'b0);
    push_req(CMD_LOAD_B, 3'd0, 3'd1, 16'hFFFF, 1'b0);
    push_req(CMD_LOAD_B, 3'd0, 3'd2, 16'h0000, 1'b0);
    push_req(CMD_LOAD_B, 3'd1, 3'd0, 16'h1234, 1'b0);
    push_req(CMD_LOAD_B, 3'd1, 3'd1, 16'h7FFF, 1'b0);
    push_req(CMD_LOAD_B, 3'd1, 3'd2, 16'hFFFF, 1'b0);
    push_compute(1'b0);
    // saturating sums
    push_req(CMD_LOAD_PI, 3'd1, 3'd5, 16'hFFFF, 1'b0);
    push_req(CMD_LOAD_A, 3'd1, 3'd1, 16'hFFFF, 1'b0);
    push_compute(1'b0);
    push_req(CMD_LOAD_A, 3'd1, 3'd0, 16'hFFFF, 1'b0);
    push_compute(1'b1);
    // top corner entries with all-ones fields
    push_req(CMD_LOAD_A, 3'd7, 3'd7, 16'hFFFF, 1'b0);
    push_req(CMD_LOAD_B, 3'd7, 3'd7, 16'hFFFF, 1'b0);
    push_req(CMD_LOAD_PI, 3'd7, 3'd7, 16'hFFFF, 1'b0);
    push_req(CMD_COMPUTE, 3'd7, 3'd7, 16'hFFFF, 1'b1);
    wait_drained();

    run_phase(4'd8, 4'd8, 0, 0, 50, 1'b0);
    run_phase(4'd0, 4'd0, 79, 0, 35, 1'b0);
    run_phase(4'd15, 4'd15, 0, 79, 40, 1'b0);
    run_phase(4'd9, 4'd1, 8, 8, 35, 1'b1);
    run_phase(4'd3, 4'd8, 0, 0, 35, 1'b0);
    run_phase(4'd1, 4'd9, 79, 0, 30, 1'b0);
    run_phase(4'd5, 4'd2, 0, 79, 35, 1'b0);
    run_phase(4'd4, 4'd6, 8, 8, 35, 1'b1);
    run_phase(4'd8, 4'd8, 0, 0, 20, 1'b0);

    if (err_cnt == 0) begin
      $display("hmm_next_emission_distribution_unit: match");
    end else begin
      $display("hmm_next_emission_distribution_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("hmm_next_emission_distribution_unit: mismatch");
    $finish;
  end

endmodule

// File: files.f
rtl/hmmned_pkg.sv
rtl/hmmned_cell.sv
rtl/hmmned_out_fifo.sv
rtl/hmm_next_emission_distribution_unit.sv
tb/tb_hmm_next_emission_distribution_unit.sv
